[rtl/sip256sid_pkg.sv]
// Shared types, constants and round functions for the 256-bit SipHash short-ID block.
// No dependencies; imported by sip256sid_round_stage and siphash_256bit_short_id_top.
`default_nettype none
package sip256sid_pkg;

  localparam logic [63:0] SIP_C0         = 64'h736f_6d65_7073_6575;
  localparam logic [63:0] SIP_C1         = 64'h646f_7261_6e64_6f6d;
  localparam logic [63:0] SIP_C2         = 64'h6c79_6765_6e65_7261;
  localparam logic [63:0] SIP_C3         = 64'h7465_6462_7974_6573;
  localparam logic [63:0] SIP_FINAL_MARK = 64'h0000_0000_0000_00ff;

  localparam int unsigned NUM_WORDS      = 4;
  localparam int unsigned NUM_ROUNDS     = 8;   // four compression, four finalization
  localparam int unsigned NUM_STAGES     = 2 * NUM_ROUNDS;
  localparam int unsigned SHORT_ID_W     = 48;
  localparam int unsigned CFG_INDEX_W    = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } sip_lanes_t;

  typedef logic [NUM_WORDS-1:0][63:0] sip_words_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned n);
    rotl64 = (x << n) | (x >> (64 - n));
  endfunction

  // First half of a SipRound: one add per lane pair.
  function automatic sip_lanes_t half_round_a(input sip_lanes_t s);
    sip_lanes_t r;
    r.a = s.a + s.b;
    r.b = rotl64(s.b, 13) ^ r.a;
    r.a = rotl64(r.a, 32);
    r.c = s.c + s.d;
    r.d = rotl64(s.d, 16) ^ r.c;
    return r;
  endfunction

  // Second half of a SipRound.
  function automatic sip_lanes_t half_round_b(input sip_lanes_t s);
    sip_lanes_t r;
    r.a = s.a + s.d;
    r.d = rotl64(s.d, 21) ^ r.a;
    r.c = s.c + s.b;
    r.b = rotl64(s.b, 17) ^ r.c;
    r.c = rotl64(r.c, 32);
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/sip256sid_round_stage.sv]
// One pipeline stage: half a SipRound plus the data-word and finalization XORs around it.
// Depends on sip256sid_pkg.
`default_nettype none
module sip256sid_round_stage #(
  parameter int unsigned ROUND = 0,
  parameter int unsigned HALF  = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire sip256sid_pkg::sip_lanes_t in_lanes,
  input  wire sip256sid_pkg::sip_words_t in_words,
  output logic                          out_valid,
  output sip256sid_pkg::sip_lanes_t     out_lanes,
  output sip256sid_pkg::sip_words_t     out_words
);
  import sip256sid_pkg::*;

  localparam logic [1:0] WIDX       = 2'(ROUND % NUM_WORDS);
  localparam bit         COMPRESS   = (ROUND < NUM_WORDS);
  localparam bit         FINAL_MARK = (ROUND == NUM_WORDS) && (HALF == 0);

  sip_lanes_t pre;
  sip_lanes_t mid;
  sip_lanes_t lanes_next;

  always_comb begin
    pre = in_lanes;
    if (HALF == 0 && COMPRESS) begin
      pre.d = in_lanes.d ^ in_words[WIDX];
    end
    if (FINAL_MARK) begin
      pre.c = in_lanes.c ^ SIP_FINAL_MARK;
    end
  end

  always_comb begin
    if (HALF == 0) begin
      mid = half_round_a(pre);
    end else begin
      mid = half_round_b(pre);
    end
  end

  always_comb begin
    lanes_next = mid;
    // fold the word into v0 once its round is complete
    if (HALF == 1 && COMPRESS) begin
      lanes_next.a = mid.a ^ in_words[WIDX];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_lanes <= lanes_next;
    out_words <= in_words;
  end

endmodule
`default_nettype wire

[rtl/siphash_256bit_short_id_top.sv]
// Top level of the 256-bit SipHash short-ID hasher: key registers, pipeline, output register.
// Depends on sip256sid_pkg and sip256sid_round_stage.
//
// Usage:
//   Keys: write key_low (index 0) and key_high (index 1) through cfg_write,
//   cfg_index and cfg_data; a write to any other index is ignored. Write them
//   only while no request is in flight.
//   Requests: drive word_zero..word_three and raise start. busy is always low,
//   so a request is taken on every clock edge at which start is high.
//   Results: hash_value and compact_id appear with result_valid for exactly one
//   cycle and are taken at the edge that ends that cycle. The first of the 16
//   half-round stages loads on the request edge, and the output register
//   follows the last of them. Results leave in request order.
//   Throughput: one request per cycle, set by the fully unrolled round pipeline.
//   The receiver cannot stall, so nothing is held back.
//   Reset: rst clears both keys to zero and drops every request in flight.
`default_nettype none
module siphash_256bit_short_id_top (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       start,
  output logic                                            busy,
  input  wire logic [63:0]                                word_zero,
  input  wire logic [63:0]                                word_one,
  input  wire logic [63:0]                                word_two,
  input  wire logic [63:0]                                word_three,
  input  wire logic                                       cfg_write,
  input  wire logic [sip256sid_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [63:0]                                cfg_data,
  output logic                                            result_valid,
  output logic [63:0]                                     hash_value,
  output logic [sip256sid_pkg::SHORT_ID_W-1:0]            compact_id
);
  import sip256sid_pkg::*;

  logic [63:0] key_low;
  logic [63:0] key_high;

  logic       stage_valid [NUM_STAGES+1];
  sip_lanes_t stage_lanes [NUM_STAGES+1];
  sip_words_t stage_words [NUM_STAGES+1];

  logic [63:0] hash_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // initial state words from the keys, lane a in the top bits
  assign stage_valid[0] = start;
  assign stage_lanes[0] = {SIP_C0 ^ key_low, SIP_C1 ^ key_high,
                           SIP_C2 ^ key_low, SIP_C3 ^ key_high};
  assign stage_words[0] = {word_three, word_two, word_one, word_zero};

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    sip256sid_round_stage #(
      .ROUND (k / 2),
      .HALF  (k % 2)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[k]),
      .in_lanes  (stage_lanes[k]),
      .in_words  (stage_words[k]),
      .out_valid (stage_valid[k+1]),
      .out_lanes (stage_lanes[k+1]),
      .out_words (stage_words[k+1])
    );
  end

  assign hash_next = stage_lanes[NUM_STAGES].a ^ stage_lanes[NUM_STAGES].b
                   ^ stage_lanes[NUM_STAGES].c ^ stage_lanes[NUM_STAGES].d;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= stage_valid[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    hash_value <= hash_next;
    compact_id <= hash_next[SHORT_ID_W-1:0];
  end

endmodule
`default_nettype wire

[tb/siphash_short_id_checker.sv]
// Checker for the 256-bit SipHash short-ID hasher: tracks the key registers, predicts each digest
// and compares results in request order. Depends on sip256sid_pkg for constants and widths.
module siphash_short_id_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic [63:0]                           word_zero,
  input  logic [63:0]                           word_one,
  input  logic [63:0]                           word_two,
  input  logic [63:0]                           word_three,
  input  logic                                  cfg_write,
  input  logic [sip256sid_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                           cfg_data,
  input  logic                                  result_valid,
  input  logic [63:0]                           hash_value,
  input  logic [sip256sid_pkg::SHORT_ID_W-1:0]  compact_id,
  output int                                    failures,
  output int                                    pending_results
);
  import sip256sid_pkg::*;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  typedef struct packed {
    logic [63:0]           hash;
    logic [SHORT_ID_W-1:0] sid;
  } digest_t;

  logic [63:0] key_lo = '0;
  logic [63:0] key_hi = '0;
  digest_t     pending_digests[$];
  digest_t     oldest;
  int          fail_count = 0;
  int          digest_count = 0;

  assign failures        = fail_count;
  assign pending_results = digest_count;

  function automatic logic [63:0] rol64(input logic [63:0] x, input int unsigned n);
    return (x << n) | (x >> (64 - n));
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t s);
    sip_state_t t;
    t = s;
    t.v0 = t.v0 + t.v1;
    t.v1 = rol64(t.v1, 13) ^ t.v0;
    t.v0 = rol64(t.v0, 32);
    t.v2 = t.v2 + t.v3;
    t.v3 = rol64(t.v3, 16) ^ t.v2;
    t.v0 = t.v0 + t.v3;
    t.v3 = rol64(t.v3, 21) ^ t.v0;
    t.v2 = t.v2 + t.v1;
    t.v1 = rol64(t.v1, 17) ^ t.v2;
    t.v2 = rol64(t.v2, 32);
    return t;
  endfunction

  function automatic digest_t predict_digest(input logic [63:0] k0, input logic [63:0] k1,
                                             input logic [63:0] w0, input logic [63:0] w1,
                                             input logic [63:0] w2, input logic [63:0] w3);
    sip_state_t      s;
    logic [3:0][63:0] w;
    logic [63:0]     h;
    digest_t         r;
    int              i;
    s.v0 = SIP_C0 ^ k0;
    s.v1 = SIP_C1 ^ k1;
    s.v2 = SIP_C2 ^ k0;
    s.v3 = SIP_C3 ^ k1;
    w = {w3, w2, w1, w0};
    // absorb each word around one round; no length word follows
    for (i = 0; i < 4; i++) begin
      s.v3 = s.v3 ^ w[i];
      s = sip_round(s);
      s.v0 = s.v0 ^ w[i];
    end
    s.v2 = s.v2 ^ SIP_FINAL_MARK;
    for (i = 0; i < 4; i++) begin
      s = sip_round(s);
    end
    h = s.v0 ^ s.v1 ^ s.v2 ^ s.v3;
    r.hash = h;
    r.sid  = h[SHORT_ID_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      key_lo = '0;
      key_hi = '0;
      pending_digests.delete();
    end else begin
      // retire the oldest digest before taking a new request on the same edge
      if (result_valid) begin
        if (pending_digests.size() == 0) begin
          $display("%0t: result with no request outstanding: hash_value %h compact_id %h",
                   $time, hash_value, compact_id);
          fail_count++;
        end else begin
          oldest = pending_digests.pop_front();
          if (hash_value !== oldest.hash) begin
            $display("%0t: hash_value mismatch: expected %h, got %h",
                     $time, oldest.hash, hash_value);
            fail_count++;
          end
          if (compact_id !== oldest.sid) begin
            $display("%0t: compact_id mismatch: expected %h, got %h",
                     $time, oldest.sid, compact_id);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        pending_digests.insert(pending_digests.size(),
                               predict_digest(key_lo, key_hi, word_zero, word_one,
                                              word_two, word_three));
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_KEY_LOW:  key_lo = cfg_data;
          REG_KEY_HIGH: key_hi = cfg_data;
          default: ;
        endcase
      end
    end
    digest_count = pending_digests.size();
  end

endmodule

[tb/tb_top.sv]
// Stimulus and verdict for siphash_256bit_short_id_top: directed and random hash requests
// under several key settings. Depends on sip256sid_pkg, the block and siphash_short_id_checker.
module tb_top;
  import sip256sid_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_TWO   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_THREE = 2'd3;
  localparam logic [63:0]            ALL_ONES        = {64{1'b1}};
  localparam int                     DRAIN_CYCLES    = 20;
  localparam int                     PHASE_ITEMS     = 275;
  localparam int                     NUM_PHASES      = 6;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [63:0]            word_zero;
  logic [63:0]            word_one;
  logic [63:0]            word_two;
  logic [63:0]            word_three;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [63:0]            cfg_data;
  logic                   result_valid;
  logic [63:0]            hash_value;
  logic [SHORT_ID_W-1:0]  compact_id;
  int                     failures;
  int                     pending_results;

  int idle_pct;
  int burst_left;

  siphash_256bit_short_id_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .word_zero    (word_zero),
    .word_one     (word_one),
    .word_two     (word_two),
    .word_three   (word_three),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .hash_value   (hash_value),
    .compact_id   (compact_id)
  );

  siphash_short_id_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .word_zero       (word_zero),
    .word_one        (word_one),
    .word_two        (word_two),
    .word_three      (word_three),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .result_valid    (result_valid),
    .hash_value      (hash_value),
    .compact_id      (compact_id),
    .failures        (failures),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("siphash_256bit_short_id_top verification failed");
    $finish;
  end

  function automatic logic [63:0] rand_word();
    logic [63:0] bit_mask;
    bit_mask = 64'd1 << $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return bit_mask;
      3:       return ~bit_mask;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Hold the request until an edge with busy low takes it; start stays high on return.
  task automatic send_request(input logic [63:0] w0, input logic [63:0] w1,
                              input logic [63:0] w2, input logic [63:0] w3);
    @(negedge clk);
    start      <= 1'b1;
    word_zero  <= w0;
    word_one   <= w1;
    word_two   <= w2;
    word_three <= w3;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drop start, wait for every outstanding digest, then let the pipeline empty.
  task automatic drain_pipeline();
    idle_cycles(1);
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_keys(input logic [63:0] k0, input logic [63:0] k1);
    drain_pipeline();
    write_reg(REG_KEY_LOW, k0);
    write_reg(REG_KEY_HIGH, k1);
  endtask

  task automatic maybe_idle();
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 49) == 0) begin
      burst_left = $urandom_range(10, 40);
    end else if ($urandom_range(0, 99) < idle_pct) begin
      idle_cycles(1);
    end
  endtask

  initial begin
    int p;
    int n;
    rst        = 1'b1;
    start      = 1'b0;
    word_zero  = '0;
    word_one   = '0;
    word_two   = '0;
    word_three = '0;
    cfg_write  = 1'b0;
    cfg_index  = REG_KEY_LOW;
    cfg_data   = '0;
    idle_pct   = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // keys still at their reset value of zero
    send_request('0, '0, '0, '0);
    send_request(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(ALL_ONES, '0, '0, '0);
    send_request('0, ALL_ONES, '0, '0);
    send_request('0, '0, ALL_ONES, '0);
    send_request('0, '0, '0, ALL_ONES);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_request(64'd1, 64'd1 << 63, 64'h0000_FFFF_FFFF_FFFF, 64'hFFFF_0000_0000_0000);
    send_request(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE);
    idle_cycles(3);
    send_request(64'h0000_0000_0000_00FF, '0, '0, 64'h0000_0000_0000_00FF);

    set_keys(ALL_ONES, '0);
    send_request('0, '0, '0, '0);
    send_request(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

    // spare indexes must leave both keys untouched
    set_keys('0, ALL_ONES);
    write_reg(REG_SPARE_TWO, {$urandom, $urandom});
    write_reg(REG_SPARE_THREE, ALL_ONES);
    send_request('0, '0, '0, '0);
    send_request(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(64'hDEAD_BEEF_0BAD_F00D, 64'd0, 64'hFFFF_FFFF_0000_0000, 64'd1);

    set_keys(ALL_ONES, ALL_ONES);
    send_request('0, '0, '0, '0);
    send_request(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       set_keys({$urandom, $urandom}, {$urandom, $urandom});
        1:       set_keys('0, '0);
        2:       set_keys(ALL_ONES, ALL_ONES);
        3: begin
          set_keys({$urandom, $urandom}, {$urandom, $urandom});
          write_reg(REG_SPARE_TWO, {$urandom, $urandom});
        end
        4:       set_keys('0, {$urandom, $urandom});
        default: set_keys({$urandom, $urandom}, ALL_ONES);
      endcase
      idle_pct = (p < 2) ? 15 : (p < 4) ? 50 : 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // hold off once per phase until every outstanding request has returned
        if (n == PHASE_ITEMS / 2) drain_pipeline();
        maybe_idle();
        send_request(rand_word(), rand_word(), rand_word(), rand_word());
      end
    end

    drain_pipeline();
    if (failures == 0) begin
      $display("siphash_256bit_short_id_top verification clean");
    end else begin
      $display("siphash_256bit_short_id_top verification failed");
    end
    $finish;
  end

endmodule
